// ----- hw/rtl/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// sm3_pkg
// Types, constants and round functions shared by the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

   localparam int WORD_BITS  = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int CHAIN_WORDS = 8;
   localparam int LEN_BITS   = 64;

   localparam logic [WORD_BITS-1:0] SM3_T0 = 32'h79cc4519;
   localparam logic [WORD_BITS-1:0] SM3_T1 = 32'h7a879d8a;
   localparam logic [7:0]           PAD_BYTE = 8'h80;
   localparam logic [WORD_BITS-1:0] PAD_MARKER = {PAD_BYTE, 24'h000000};

   localparam logic [CHAIN_WORDS-1:0][WORD_BITS-1:0] SM3_IV = {
      32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
      32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINISH,
      ST_OUTPUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      PH_NONE,
      PH_MARKER,
      PH_ZEROS,
      PH_LEN_LO,
      PH_DONE
   } pad_phase_type;

   typedef enum logic [2:0] {
      SEL_DATA,
      SEL_TAIL,
      SEL_MARKER,
      SEL_ZERO,
      SEL_LEN_HI,
      SEL_LEN_LO
   } word_sel_type;

   typedef struct packed {
      logic         push;
      word_sel_type sel;
      logic         add_bits;
      logic         round_en;
      logic         finish_en;
      logic         out_advance;
      logic         clear;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_full;
      logic slot_at_len;
      logic round_last;
      logic out_last;
   } dp_status_type;

   function automatic logic [WORD_BITS-1:0] rotl32(input logic [WORD_BITS-1:0] x,
                                                   input logic [4:0] n);
      logic [2*WORD_BITS-1:0] t;
      t = {x, x} << n;
      return t[2*WORD_BITS-1:WORD_BITS];
   endfunction

   function automatic logic [WORD_BITS-1:0] perm0(input logic [WORD_BITS-1:0] x);
      return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
   endfunction

   function automatic logic [WORD_BITS-1:0] perm1(input logic [WORD_BITS-1:0] x);
      return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
   endfunction

   // round constant already rotated left by the round number modulo 32
   function automatic logic [WORD_BITS-1:0] tj_rot(input logic [5:0] round);
      logic [WORD_BITS-1:0] base;
      base = (round < 6'd16) ? SM3_T0 : SM3_T1;
      return rotl32(base, round[4:0]);
   endfunction

endpackage

// ----- hw/rtl/sm3_if.sv -----
// ----------------------------------------------------------------------------
// sm3_if
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last_word;

   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        digest_last;

   modport source (output valid, digest_word, word_index, digest_last, input ready);
   modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// ----- hw/rtl/sm3_ctrl.sv -----
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: word intake, padding, round stepping and digest readout.
// ----------------------------------------------------------------------------
module sm3_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   input  logic                  req_short,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  sm3_pkg::dp_status_type status,
   output sm3_pkg::dp_cmd_type   cmd
);
   import sm3_pkg::*;

   ctrl_state_type state_ff, state_in;
   pad_phase_type  phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_NONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '{push: 1'b0, sel: SEL_DATA, add_bits: 1'b0, round_en: 1'b0,
                    finish_en: 1'b0, out_advance: 1'b0, clear: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push     = 1'b1;
               cmd.add_bits = 1'b1;
               cmd.sel      = req_short ? SEL_TAIL : SEL_DATA;
               if (!req_last) begin
                  phase_in = PH_NONE;
               end else if (req_short) begin
                  phase_in = PH_ZEROS;
               end else begin
                  phase_in = PH_MARKER;
               end
               if (status.slot_full) begin
                  state_in = ST_ROUND;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            unique case (phase_ff)
               PH_MARKER: begin
                  cmd.sel  = SEL_MARKER;
                  phase_in = PH_ZEROS;
               end
               PH_ZEROS: begin
                  if (status.slot_at_len) begin
                     cmd.sel  = SEL_LEN_HI;
                     phase_in = PH_LEN_LO;
                  end else begin
                     cmd.sel = SEL_ZERO;
                  end
               end
               PH_LEN_LO: begin
                  cmd.sel  = SEL_LEN_LO;
                  phase_in = PH_DONE;
               end
               default: begin
                  cmd.push = 1'b0;
                  state_in = ST_IDLE;
               end
            endcase
            if (cmd.push && status.slot_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish_en = 1'b1;
            unique case (phase_ff)
               PH_NONE: state_in = ST_IDLE;
               PH_DONE: state_in = ST_OUTPUT;
               default: state_in = ST_PAD;
            endcase
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_advance = 1'b1;
               if (status.out_last) begin
                  cmd.clear = 1'b1;
                  phase_in  = PH_NONE;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/sm3_datapath.sv -----
// ----------------------------------------------------------------------------
// sm3_datapath
// Block window, message expansion, one compression round per cycle,
// chaining value and bit length.
// ----------------------------------------------------------------------------
module sm3_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           data_word,
   input  logic [2:0]            byte_count,
   input  logic                  last_word,
   input  sm3_pkg::dp_cmd_type   cmd,
   output sm3_pkg::dp_status_type status,
   output logic [31:0]           digest_word,
   output logic [2:0]            word_index,
   output logic                  digest_last
);
   import sm3_pkg::*;

   logic [CHAIN_WORDS-1:0][WORD_BITS-1:0] chain_ff, chain_in;
   logic [BLOCK_WORDS-1:0][WORD_BITS-1:0] win_ff, win_in;
   logic [CHAIN_WORDS-1:0][WORD_BITS-1:0] regs_ff, regs_in, regs_next;
   logic [LEN_BITS-1:0] bits_ff, bits_in;
   logic [3:0]          slot_ff, slot_in;
   logic [5:0]          round_ff, round_in;
   logic [2:0]          out_idx_ff, out_idx_in;

   logic [WORD_BITS-1:0] push_word, tail_word, new_w;
   logic [WORD_BITS-1:0] a12, ss1, ss2, ff_val, gg_val, tt1, tt2;
   logic [2:0]           cnt_eff;
   logic                 block_done;

   assign block_done = cmd.push && (slot_ff == 4'd15);

   // effective byte count: full word unless a last word says fewer
   always_comb begin
      if (!last_word || byte_count > 3'd4) begin
         cnt_eff = 3'd4;
      end else begin
         cnt_eff = byte_count;
      end
   end

   // last partial word with its pad byte in place
   always_comb begin
      case (cnt_eff[1:0])
         2'd0:    tail_word = PAD_MARKER;
         2'd1:    tail_word = {data_word[31:24], PAD_BYTE, 16'h0000};
         2'd2:    tail_word = {data_word[31:16], PAD_BYTE, 8'h00};
         default: tail_word = {data_word[31:8], PAD_BYTE};
      endcase
   end

   always_comb begin
      unique case (cmd.sel)
         SEL_DATA:   push_word = data_word;
         SEL_TAIL:   push_word = tail_word;
         SEL_MARKER: push_word = PAD_MARKER;
         SEL_ZERO:   push_word = '0;
         SEL_LEN_HI: push_word = bits_ff[LEN_BITS-1:WORD_BITS];
         SEL_LEN_LO: push_word = bits_ff[WORD_BITS-1:0];
         default:    push_word = '0;
      endcase
   end

   // expansion: window holds w[j..j+15], new word is w[j+16]
   assign new_w = perm1(win_ff[0] ^ win_ff[7] ^ rotl32(win_ff[13], 5'd15))
                  ^ rotl32(win_ff[3], 5'd7) ^ win_ff[10];

   always_comb begin
      a12 = rotl32(regs_ff[0], 5'd12);
      ss1 = rotl32(a12 + regs_ff[4] + tj_rot(round_ff), 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff_val = regs_ff[0] ^ regs_ff[1] ^ regs_ff[2];
         gg_val = regs_ff[4] ^ regs_ff[5] ^ regs_ff[6];
      end else begin
         ff_val = (regs_ff[0] & regs_ff[1]) | (regs_ff[0] & regs_ff[2])
                  | (regs_ff[1] & regs_ff[2]);
         gg_val = (regs_ff[4] & regs_ff[5]) | (~regs_ff[4] & regs_ff[6]);
      end
      tt1 = ff_val + regs_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2 = gg_val + regs_ff[7] + ss1 + win_ff[0];
      regs_next[0] = tt1;
      regs_next[1] = regs_ff[0];
      regs_next[2] = rotl32(regs_ff[1], 5'd9);
      regs_next[3] = regs_ff[2];
      regs_next[4] = perm0(tt2);
      regs_next[5] = regs_ff[4];
      regs_next[6] = rotl32(regs_ff[5], 5'd19);
      regs_next[7] = regs_ff[6];
   end

   always_comb begin
      win_in     = win_ff;
      slot_in    = slot_ff;
      regs_in    = regs_ff;
      round_in   = round_ff;
      chain_in   = chain_ff;
      bits_in    = bits_ff;
      out_idx_in = out_idx_ff;

      if (cmd.push) begin
         win_in  = {push_word, win_ff[BLOCK_WORDS-1:1]};
         slot_in = slot_ff + 4'd1;
      end else if (cmd.round_en) begin
         win_in = {new_w, win_ff[BLOCK_WORDS-1:1]};
      end

      if (block_done) begin
         regs_in  = chain_ff;
         round_in = '0;
      end else if (cmd.round_en) begin
         regs_in  = regs_next;
         round_in = round_ff + 6'd1;
      end

      if (cmd.finish_en) begin
         chain_in = chain_ff ^ regs_ff;
      end

      if (cmd.add_bits) begin
         bits_in = bits_ff + {{(LEN_BITS-6){1'b0}}, cnt_eff, 3'b000};
      end

      if (cmd.out_advance) begin
         out_idx_in = out_idx_ff + 3'd1;
      end

      if (cmd.clear) begin
         chain_in   = SM3_IV;
         bits_in    = '0;
         slot_in    = '0;
         out_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= SM3_IV;
         regs_ff    <= '0;
         bits_ff    <= '0;
         slot_ff    <= '0;
         round_ff   <= '0;
         out_idx_ff <= '0;
      end else begin
         chain_ff   <= chain_in;
         regs_ff    <= regs_in;
         bits_ff    <= bits_in;
         slot_ff    <= slot_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign status.slot_full   = (slot_ff == 4'd15);
   assign status.slot_at_len = (slot_ff == 4'd14);
   assign status.round_last  = (round_ff == 6'd63);
   assign status.out_last    = (out_idx_ff == 3'd7);

   assign digest_word = chain_ff[out_idx_ff];
   assign word_index  = out_idx_ff;
   assign digest_last = (out_idx_ff == 3'd7);

endmodule

// ----- hw/rtl/sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// sm3_hash_engine
// SM3 hash over a stream of big-endian 32-bit message words.
// ----------------------------------------------------------------------------
// Message words are taken one per cycle until a 16-word block is full; the
// block then runs 64 compression rounds on a single round unit, one round per
// cycle, after which the result is folded into the chaining value. After the
// word marked last, the engine inserts the padding and length words at one
// per cycle, pausing while a full block is compressed (up to 18 words, one or
// two more compressions), and then presents the eight digest words, index 0
// first, on the response channel.
// No new word is taken until the last digest word has been accepted; the
// engine is then back at the initial vector for the next message.
module sm3_hash_engine (
   input  logic     clock,
   input  logic     reset,
   sm3_req_if.sink  req_if,
   sm3_rsp_if.source rsp_if
);
   import sm3_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_short;

   assign req_short = req_if.last_word && (req_if.byte_count < 3'd4);

   sm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_word),
      .req_short (req_short),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .status    (status),
      .cmd       (cmd)
   );

   sm3_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_word   (req_if.data_word),
      .byte_count  (req_if.byte_count),
      .last_word   (req_if.last_word),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_if.digest_word),
      .word_index  (rsp_if.word_index),
      .digest_last (rsp_if.digest_last)
   );

endmodule
